>>> design/glp_pkg.sv
// Shared types and constants for the GNSS info line parser.
// No dependencies; the top level and glp_emitter import this package.
`timescale 1ns / 1ps

package glp_pkg;

  // Default sizes of the capture stores.
  localparam int COORD_CHARS_DEF = 11;
  localparam int TIME_DIGITS_DEF = 14;

  // Fixed result field widths.
  localparam int TS_BCD_W = 56;
  localparam int TS_CNT_W = 4;
  localparam int ALT_W    = 15;

  localparam logic [ALT_W-1:0] ALT_MAX = 15'd32767;

  // Input operation codes.
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // ASCII characters the parser reacts to.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_C     = 8'h43;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_HDR = 2'd0,
    KIND_LAT = 2'd1,
    KIND_LON = 2'd2
  } kind_e;

  // Record fields that the parser hands to the result sequencer.
  typedef struct packed {
    logic [7:0]          run_status;
    logic [7:0]          fix_status;
    logic [TS_BCD_W-1:0] ts_bcd;
    logic [TS_CNT_W-1:0] ts_digits;
    logic [ALT_W-1:0]    altitude;
  } rec_t;

endpackage

>>> design/glp_in_if.sv
// Input channel of the GNSS info line parser: valid/ready plus one byte item.
// Depends on nothing.
`timescale 1ns / 1ps

interface glp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

>>> design/glp_out_if.sv
// Result channel of the GNSS info line parser: valid/ready plus one result item.
// Depends on nothing.
`timescale 1ns / 1ps

interface glp_out_if;
  logic        valid;
  logic        ready;
  logic        record_valid;
  logic [7:0]  run_status;
  logic [7:0]  fix_status;
  logic [55:0] timestamp_bcd;
  logic [3:0]  timestamp_digits;
  logic [14:0] altitude_m;
  logic [1:0]  text_kind;
  logic [7:0]  text_char;
  logic        last_item;

  modport source (
    output valid, output record_valid, output run_status, output fix_status,
    output timestamp_bcd, output timestamp_digits, output altitude_m,
    output text_kind, output text_char, output last_item, input ready
  );
  modport sink (
    input valid, input record_valid, input run_status, input fix_status,
    input timestamp_bcd, input timestamp_digits, input altitude_m,
    input text_kind, input text_char, input last_item, output ready
  );
endinterface

>>> design/gnss_info_line_parser_top.sv
// Top level of the GNSS info line parser: byte parser and record capture.
// Depends on glp_pkg, glp_in_if, glp_out_if and glp_emitter.
`timescale 1ns / 1ps

// The block takes modem reply bytes, one per transfer, and looks for the
// CGNSINF header. The byte after the header is skipped, then comma-separated
// fields one through nine are parsed: the last character of field one (run
// status) and field two (fix status), the timestamp digits before the dot as
// packed BCD, the raw latitude and longitude characters, and the integer part
// of the altitude, saturated at 32767. A carriage return commits the record.
// With fix status '1' the block delivers a header result followed by one
// result per latitude character and one per longitude character; otherwise
// it delivers a single result with record_valid low. The last result of a
// commit carries last_item. Only the first record after a clear (opcode 1)
// or reset is used; later bytes are accepted and dropped until the next clear.
// Rate: one input byte per clock cycle while parsing. With fix status '1' a commit
// produces 1 + latitude length + longitude length results at one per cycle while
// the receiver takes them, limited by the single read port of the coordinate
// memory; from the commit until the last of them has left the memory read
// stage, the input is held off, so a stalling receiver holds it off longer. No
// clearing pass is needed after reset. The output register lets the input
// side keep accepting while a result waits to be taken.

module gnss_info_line_parser_top #(
  parameter int COORD_CHARS = glp_pkg::COORD_CHARS_DEF,
  parameter int TIME_DIGITS = glp_pkg::TIME_DIGITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  glp_in_if.sink     in_i,
  glp_out_if.source  out_o
);
  import glp_pkg::*;

  localparam int LEN_W = $clog2(COORD_CHARS + 1);
  localparam int AW    = $clog2(2 * COORD_CHARS);
  localparam int BCD_W = 4 * TIME_DIGITS;
  localparam int CNT_W = $clog2(TIME_DIGITS + 1);

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_COLON,
    PH_FIELDS,
    PH_DONE
  } phase_e;

  // Header text, one character per match position.
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h43;  // C
      3'd1:    c = 8'h47;  // G
      3'd2:    c = 8'h4E;  // N
      3'd3:    c = 8'h53;  // S
      3'd4:    c = 8'h49;  // I
      3'd5:    c = 8'h4E;  // N
      3'd6:    c = 8'h46;  // F
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Parser state.
  phase_e           phase_q, phase_d;
  logic [2:0]       match_q, match_d;
  logic [3:0]       field_q, field_d;
  logic [7:0]       run_q, run_d;
  logic [7:0]       fix_q, fix_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [CNT_W-1:0] tcnt_q, tcnt_d;
  logic             past_dot_q, past_dot_d;
  logic [LEN_W-1:0] lat_len_q, lat_len_d;
  logic [LEN_W-1:0] lon_len_q, lon_len_d;
  logic [ALT_W-1:0] alt_q, alt_d;
  logic             alt_int_q, alt_int_d;

  logic             accept, busy, commit, is_digit;
  logic [7:0]       b;
  logic [3:0]       digit;
  logic [ALT_W+3:0] alt_sum;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [BCD_W+TS_BCD_W-1:0] bcd_ext;
  logic [CNT_W+TS_CNT_W-1:0] cnt_ext;
  rec_t             rec;

  assign in_i.ready = !busy;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.rx_byte;
  assign is_digit   = b inside {[CH_ZERO:CH_NINE]};
  assign digit      = 4'(b - CH_ZERO);
  assign alt_sum    = (ALT_W+4)'({alt_q, 3'b000}) + (ALT_W+4)'({alt_q, 1'b0})
                    + (ALT_W+4)'(digit);

  always_comb begin
    phase_d    = phase_q;
    match_d    = match_q;
    field_d    = field_q;
    run_d      = run_q;
    fix_d      = fix_q;
    bcd_d      = bcd_q;
    tcnt_d     = tcnt_q;
    past_dot_d = past_dot_q;
    lat_len_d  = lat_len_q;
    lon_len_d  = lon_len_q;
    alt_d      = alt_q;
    alt_int_d  = alt_int_q;
    commit     = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = AW'(lat_len_q);

    if (accept && in_i.opcode == OP_CLEAR) begin
      phase_d    = PH_SEARCH;
      match_d    = '0;
      field_d    = 4'd1;
      run_d      = '0;
      fix_d      = '0;
      bcd_d      = '0;
      tcnt_d     = '0;
      past_dot_d = 1'b0;
      lat_len_d  = '0;
      lon_len_d  = '0;
      alt_d      = '0;
      alt_int_d  = 1'b1;
    end else if (accept) begin
      case (phase_q)
        PH_SEARCH: begin
          if (b == hdr_char(match_q)) begin
            match_d = match_q + 3'd1;
            if (match_q == 3'd6) begin
              phase_d = PH_COLON;
            end
          end else begin
            match_d = (b == CH_C) ? 3'd1 : 3'd0;
          end
        end
        PH_COLON: begin
          if (b == CH_CR) begin
            commit  = 1'b1;
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_FIELDS;
          end
        end
        PH_FIELDS: begin
          if (b == CH_CR) begin
            commit  = 1'b1;
            phase_d = PH_DONE;
          end else if (field_q <= 4'd9) begin
            if (b == CH_COMMA) begin
              field_d   = field_q + 4'd1;
              alt_int_d = 1'b1;
            end else begin
              case (field_q)
                4'd1: run_d = b;
                4'd2: fix_d = b;
                4'd3: begin
                  if (is_digit && !past_dot_q && tcnt_q < CNT_W'(TIME_DIGITS)) begin
                    bcd_d  = {bcd_q[BCD_W-5:0], digit};
                    tcnt_d = tcnt_q + 1'b1;
                  end
                  if (b == CH_DOT) begin
                    past_dot_d = 1'b1;
                  end
                end
                4'd4: begin
                  if (lat_len_q < LEN_W'(COORD_CHARS)) begin
                    wr_en     = 1'b1;
                    wr_addr   = AW'(lat_len_q);
                    lat_len_d = lat_len_q + 1'b1;
                  end
                end
                4'd5: begin
                  if (lon_len_q < LEN_W'(COORD_CHARS)) begin
                    wr_en     = 1'b1;
                    wr_addr   = AW'(COORD_CHARS) + AW'(lon_len_q);
                    lon_len_d = lon_len_q + 1'b1;
                  end
                end
                4'd6: begin
                  if (is_digit && alt_int_q) begin
                    alt_d = (alt_sum > (ALT_W+4)'(ALT_MAX)) ? ALT_MAX : alt_sum[ALT_W-1:0];
                  end
                  if (b == CH_DOT) begin
                    alt_int_d = 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SEARCH;
      match_q    <= '0;
      field_q    <= 4'd1;
      run_q      <= '0;
      fix_q      <= '0;
      bcd_q      <= '0;
      tcnt_q     <= '0;
      past_dot_q <= 1'b0;
      lat_len_q  <= '0;
      lon_len_q  <= '0;
      alt_q      <= '0;
      alt_int_q  <= 1'b1;
    end else begin
      phase_q    <= phase_d;
      match_q    <= match_d;
      field_q    <= field_d;
      run_q      <= run_d;
      fix_q      <= fix_d;
      bcd_q      <= bcd_d;
      tcnt_q     <= tcnt_d;
      past_dot_q <= past_dot_d;
      lat_len_q  <= lat_len_d;
      lon_len_q  <= lon_len_d;
      alt_q      <= alt_d;
      alt_int_q  <= alt_int_d;
    end
  end

  // The BCD register holds zeros above its captured digits, so the result
  // field is its low end, widened or cut to the fixed field width.
  assign bcd_ext = {{TS_BCD_W{1'b0}}, bcd_q};
  assign cnt_ext = {{TS_CNT_W{1'b0}}, tcnt_q};

  always_comb begin
    rec.run_status = run_q;
    rec.fix_status = fix_q;
    rec.ts_bcd     = bcd_ext[TS_BCD_W-1:0];
    rec.ts_digits  = cnt_ext[TS_CNT_W-1:0];
    rec.altitude   = alt_q;
  end

  glp_emitter #(
    .COORD_CHARS(COORD_CHARS)
  ) u_emitter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (b),
    .commit_i  (commit),
    .rec_i     (rec),
    .lat_len_i (lat_len_q),
    .lon_len_i (lon_len_q),
    .busy_o    (busy),
    .out_o     (out_o)
  );

endmodule

>>> design/glp_emitter.sv
// Coordinate character memory and result sequencer of the GNSS info line parser.
// Depends on glp_pkg and glp_out_if.
`timescale 1ns / 1ps

module glp_emitter #(
  parameter int COORD_CHARS = glp_pkg::COORD_CHARS_DEF,
  localparam int LEN_W = $clog2(COORD_CHARS + 1),
  localparam int AW    = $clog2(2 * COORD_CHARS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             commit_i,
  input  glp_pkg::rec_t    rec_i,
  input  logic [LEN_W-1:0] lat_len_i,
  input  logic [LEN_W-1:0] lon_len_i,
  output logic             busy_o,
  glp_out_if.source        out_o
);
  import glp_pkg::*;

  // Latitude characters sit at the bottom, longitude characters above them.
  logic [7:0] mem_q [2*COORD_CHARS];
  logic [7:0] rdata_q;

  // Sequencer state.
  logic             em_act_q, em_act_d;
  logic             em_ok_q, em_ok_d;
  kind_e            em_kind_q, em_kind_d;
  logic [LEN_W-1:0] em_idx_q, em_idx_d;

  // Read stage: the memory word for this item lands in rdata_q.
  logic  s1_vld_q;
  logic  s1_ok_q;
  logic  s1_last_q;
  kind_e s1_kind_q;

  // Output register.
  logic       o_vld_q;
  logic       o_ok_q;
  logic       o_last_q;
  kind_e      o_kind_q;
  logic [7:0] o_char_q;
  rec_t       o_rec_q;

  logic             s1_move, issue, req_last;
  logic [LEN_W-1:0] idx_nx;
  logic [AW-1:0]    rd_addr;

  assign s1_move = s1_vld_q && (!o_vld_q || out_o.ready);
  assign issue   = em_act_q && (!s1_vld_q || s1_move);
  assign idx_nx  = em_idx_q + 1'b1;
  assign busy_o  = em_act_q || s1_vld_q;

  always_comb begin
    rd_addr = AW'(em_idx_q);
    if (em_kind_q == KIND_LON) begin
      rd_addr = AW'(COORD_CHARS) + AW'(em_idx_q);
    end
  end

  // Walk header, latitude characters, longitude characters.
  always_comb begin
    em_act_d  = em_act_q;
    em_ok_d   = em_ok_q;
    em_kind_d = em_kind_q;
    em_idx_d  = em_idx_q;
    req_last  = 1'b1;
    if (commit_i) begin
      em_act_d  = 1'b1;
      em_ok_d   = (rec_i.fix_status == CH_ONE);
      em_kind_d = KIND_HDR;
      em_idx_d  = '0;
    end else if (issue) begin
      case (em_kind_q)
        KIND_HDR: begin
          if (!em_ok_q) begin
            req_last = 1'b1;
            em_act_d = 1'b0;
          end else begin
            req_last = (lat_len_i == '0) && (lon_len_i == '0);
            if (lat_len_i != '0) begin
              em_kind_d = KIND_LAT;
            end else if (lon_len_i != '0) begin
              em_kind_d = KIND_LON;
            end else begin
              em_act_d = 1'b0;
            end
          end
        end
        KIND_LAT: begin
          req_last = (idx_nx == lat_len_i) && (lon_len_i == '0);
          if (idx_nx != lat_len_i) begin
            em_idx_d = idx_nx;
          end else if (lon_len_i != '0) begin
            em_kind_d = KIND_LON;
            em_idx_d  = '0;
          end else begin
            em_act_d = 1'b0;
          end
        end
        KIND_LON: begin
          req_last = (idx_nx == lon_len_i);
          if (idx_nx != lon_len_i) begin
            em_idx_d = idx_nx;
          end else begin
            em_act_d = 1'b0;
          end
        end
        default: begin
          req_last = 1'b1;
          em_act_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_act_q <= 1'b0;
      s1_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      em_act_q <= em_act_d;
      if (issue) begin
        s1_vld_q <= 1'b1;
      end else if (s1_move) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_move) begin
        o_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        o_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    em_ok_q   <= em_ok_d;
    em_kind_q <= em_kind_d;
    em_idx_q  <= em_idx_d;
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (issue) begin
      rdata_q   <= mem_q[rd_addr];
      s1_ok_q   <= em_ok_q;
      s1_kind_q <= em_kind_q;
      s1_last_q <= req_last;
    end
    if (s1_move) begin
      o_ok_q   <= s1_ok_q;
      o_kind_q <= s1_kind_q;
      o_last_q <= s1_last_q;
      o_char_q <= (s1_kind_q == KIND_HDR) ? 8'h00 : rdata_q;
      o_rec_q  <= rec_i;
    end
  end

  // The parser input is held off while the read stage is full, so the record
  // fields are stable when a result moves into the output register, and they
  // travel with it from there.
  assign out_o.valid            = o_vld_q;
  assign out_o.record_valid     = o_ok_q;
  assign out_o.run_status       = o_rec_q.run_status;
  assign out_o.fix_status       = o_rec_q.fix_status;
  assign out_o.timestamp_bcd    = o_ok_q ? o_rec_q.ts_bcd : '0;
  assign out_o.timestamp_digits = o_ok_q ? o_rec_q.ts_digits : '0;
  assign out_o.altitude_m       = o_ok_q ? o_rec_q.altitude : '0;
  assign out_o.text_kind        = o_kind_q;
  assign out_o.text_char        = o_char_q;
  assign out_o.last_item        = o_last_q;

endmodule
